>>> rtl/core/u8rps_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 resync pair swap package
// Byte class limits and small helpers shared by the resynchronizer files.
// ----------------------------------------------------------------------------
package u8rps_pkg;

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] CONT_LIMIT  = 8'hC0;
   localparam logic [7:0] LEAD3_BASE  = 8'hE0;
   localparam logic [7:0] LEAD4_BASE  = 8'hF0;

   localparam int unsigned CHAR_BYTES = 4;
   localparam int unsigned RUN_BYTES  = 2 * CHAR_BYTES;

   typedef logic [8*CHAR_BYTES-1:0] char_type;
   typedef logic [8*RUN_BYTES-1:0]  run_type;
   typedef logic [2:0]              len_type;
   typedef logic [3:0]              run_len_type;

   function automatic char_type keep_bytes(char_type ch, len_type len);
      char_type res;
      res = '0;
      for (int i = 0; i < CHAR_BYTES; i++) begin
         if (len_type'(i) < len) begin
            res[8*i +: 8] = ch[8*i +: 8];
         end
      end
      return res;
   endfunction

   // A character whose first byte is NUL produces no output bytes.
   function automatic len_type emit_len(char_type ch, len_type len);
      return (ch[7:0] == 8'h00) ? len_type'(0) : len;
   endfunction

   function automatic len_type lead_len(logic [7:0] b);
      len_type res;
      if (b < LEAD3_BASE) begin
         res = len_type'(2);
      end else if (b < LEAD4_BASE) begin
         res = len_type'(3);
      end else begin
         res = len_type'(4);
      end
      return res;
   endfunction

endpackage

>>> rtl/core/u8rps_if.sv
// ----------------------------------------------------------------------------
// UTF-8 resync pair swap channels
// Valid/ready channels for the raw byte input and the reordered byte output.
// ----------------------------------------------------------------------------
interface u8rps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface u8rps_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

>>> rtl/core/utf8_resync_pair_swap.sv
// Path: an accepted byte waits in the input register until the result register is free; its
// result bytes are then loaded into the result register and offered on rsp_bus in order.
// Throughput: one input beat per cycle while the result register is empty or passing its
// last beat; a run of n bytes caused by one input beat drains one byte per cycle while
// rsp_bus is ready, and the next input beat waits until the run's last byte is taken.
// Reset: synchronous; clears the held and partial characters and empties both registers.
// ----------------------------------------------------------------------------
// UTF-8 resync pair swap
// Assembles UTF-8 characters from a byte stream and emits them in swapped pairs.
// ----------------------------------------------------------------------------
module utf8_resync_pair_swap (
   input logic         clock,
   input logic         reset,
   u8rps_req_if.sink   req_bus,
   u8rps_rsp_if.source rsp_bus
);
   import u8rps_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff, in_data_in;
   logic        in_eos_ff, in_eos_in;

   char_type    held_char_ff, held_char_in;
   len_type     held_len_ff, held_len_in;
   logic        have_held_ff, have_held_in;
   char_type    build_char_ff, build_char_in;
   len_type     build_needed_ff, build_needed_in;
   len_type     build_count_ff, build_count_in;

   run_type     run_ff, run_in;
   run_len_type run_cnt_ff, run_cnt_in;

   logic        slot_free, advance, req_fire, rsp_fire;

   run_type     new_run;
   run_len_type new_run_len;
   logic        fresh, do_complete;
   char_type    cplt_char;
   len_type     cplt_len;
   len_type     next_count;
   len_type     first_len;
   len_type     second_len;

   assign slot_free = (run_cnt_ff == '0) || ((run_cnt_ff == run_len_type'(1)) && rsp_bus.ready);
   assign advance   = in_valid_ff && slot_free;
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign rsp_fire  = rsp_bus.valid && rsp_bus.ready;

   assign req_bus.ready    = !in_valid_ff || slot_free;
   assign rsp_bus.valid    = (run_cnt_ff != '0);
   assign rsp_bus.out_byte = run_ff[7:0];
   assign rsp_bus.last     = (run_cnt_ff == run_len_type'(1));

   always_comb begin
      held_char_in    = held_char_ff;
      held_len_in     = held_len_ff;
      have_held_in    = have_held_ff;
      build_char_in   = build_char_ff;
      build_needed_in = build_needed_ff;
      build_count_in  = build_count_ff;
      new_run         = '0;
      new_run_len     = '0;
      fresh           = 1'b1;
      do_complete     = 1'b0;
      cplt_char       = '0;
      cplt_len        = '0;
      next_count      = build_count_ff + len_type'(1);
      first_len       = '0;
      second_len      = emit_len(held_char_ff, held_len_ff);

      if (in_eos_ff) begin
         if (have_held_ff) begin
            new_run     = run_type'(keep_bytes(held_char_ff, held_len_ff));
            new_run_len = run_len_type'(second_len);
         end
         held_char_in    = '0;
         held_len_in     = '0;
         have_held_in    = 1'b0;
         build_char_in   = '0;
         build_needed_in = '0;
         build_count_in  = '0;
      end else begin
         if (build_needed_ff != '0) begin
            if ((in_data_ff >= ASCII_LIMIT) && (in_data_ff < CONT_LIMIT)) begin
               fresh = 1'b0;
               build_char_in = build_char_ff |
                  (char_type'(in_data_ff) << {build_count_ff[1:0], 3'b000});
               build_count_in = next_count;
               if (next_count >= build_needed_ff) begin
                  do_complete     = 1'b1;
                  cplt_char       = build_char_in;
                  cplt_len        = build_needed_ff;
                  build_char_in   = '0;
                  build_needed_in = '0;
                  build_count_in  = '0;
               end
            end else begin
               build_char_in   = '0;
               build_needed_in = '0;
               build_count_in  = '0;
            end
         end

         if (fresh) begin
            if (in_data_ff < ASCII_LIMIT) begin
               do_complete = 1'b1;
               cplt_char   = char_type'(in_data_ff);
               cplt_len    = len_type'(1);
            end else if (in_data_ff >= CONT_LIMIT) begin
               build_char_in   = char_type'(in_data_ff);
               build_count_in  = len_type'(1);
               build_needed_in = lead_len(in_data_ff);
            end
         end

         if (do_complete) begin
            if (!have_held_ff) begin
               held_char_in = cplt_char;
               held_len_in  = cplt_len;
               have_held_in = 1'b1;
            end else begin
               first_len    = emit_len(cplt_char, cplt_len);
               new_run      = run_type'(keep_bytes(cplt_char, cplt_len)) |
                  (run_type'(keep_bytes(held_char_ff, held_len_ff)) << {first_len, 3'b000});
               new_run_len  = run_len_type'(first_len) + run_len_type'(second_len);
               held_char_in = '0;
               held_len_in  = '0;
               have_held_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      in_data_in  = in_data_ff;
      in_eos_in   = in_eos_ff;
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_data_in  = req_bus.data_byte;
         in_eos_in   = req_bus.end_of_stream;
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      run_in     = run_ff;
      run_cnt_in = run_cnt_ff;
      if (advance) begin
         run_in     = new_run;
         run_cnt_in = new_run_len;
      end else if (rsp_fire) begin
         run_in     = run_ff >> 8;
         run_cnt_in = run_cnt_ff - run_len_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      in_eos_ff  <= in_eos_in;
      run_ff     <= run_in;
      if (reset) begin
         in_valid_ff     <= 1'b0;
         run_cnt_ff      <= '0;
         held_char_ff    <= '0;
         held_len_ff     <= '0;
         have_held_ff    <= 1'b0;
         build_char_ff   <= '0;
         build_needed_ff <= '0;
         build_count_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         run_cnt_ff  <= run_cnt_in;
         if (advance) begin
            held_char_ff    <= held_char_in;
            held_len_ff     <= held_len_in;
            have_held_ff    <= have_held_in;
            build_char_ff   <= build_char_in;
            build_needed_ff <= build_needed_in;
            build_count_ff  <= build_count_in;
         end
      end
   end

endmodule

>>> rtl/core/u8rps_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 resync pair swap checker
// Port-level properties of the resynchronizer, bound to the top level.
// ----------------------------------------------------------------------------
module u8rps_props (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // A result beat that is held back keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last)))
      else $error("stalled result beat changed");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // NUL characters are never emitted, and no other emitted byte is zero.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> (rsp_out_byte != 8'h00))
      else $error("zero byte emitted");

   // A run continues without a gap until its last beat.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("run ended before its last beat");

endmodule

bind utf8_resync_pair_swap u8rps_props u_u8rps_props (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_out_byte (rsp_bus.out_byte),
   .rsp_last     (rsp_bus.last)
);

>>> dv/u8rps_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 resync pair swap checker
// Watches the byte and result channels, predicts the reordered byte stream
// for every accepted input beat and compares each result beat with it.
// ----------------------------------------------------------------------------
module u8rps_checker
   import u8rps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_stream,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last,
   output int         mismatch_count,
   output int         bytes_owed
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } out_beat_type;

   out_beat_type owed_q[$];
   out_beat_type run_q[$];

   char_type held_char;
   len_type  held_len;
   logic     have_held;
   char_type build_char;
   len_type  build_needed;
   len_type  build_count;

   task automatic clear_build();
      build_char   = '0;
      build_needed = '0;
      build_count  = '0;
   endtask

   task automatic clear_all();
      held_char = '0;
      held_len  = '0;
      have_held = 1'b0;
      clear_build();
   endtask

   task automatic emit_bytes(input char_type ch, input len_type len);
      out_beat_type beat;
      if (ch[7:0] != 8'h00) begin
         for (int i = 0; i < int'(len) && i < CHAR_BYTES; i++) begin
            beat.out_byte = ch[8*i +: 8];
            beat.last     = 1'b0;
            run_q.push_back(beat);
         end
      end
   endtask

   task automatic pair_char(input char_type ch, input len_type len);
      if (!have_held) begin
         held_char = ch;
         held_len  = len;
         have_held = 1'b1;
      end else begin
         emit_bytes(ch, len);
         emit_bytes(held_char, held_len);
         held_char = '0;
         held_len  = '0;
         have_held = 1'b0;
      end
   endtask

   task automatic start_char(input logic [7:0] b);
      if (b < ASCII_LIMIT) begin
         pair_char(char_type'(b), len_type'(1));
      end else if (b >= CONT_LIMIT) begin
         build_char  = char_type'(b);
         build_count = len_type'(1);
         if (b < LEAD3_BASE) begin
            build_needed = len_type'(2);
         end else if (b < LEAD4_BASE) begin
            build_needed = len_type'(3);
         end else begin
            build_needed = len_type'(4);
         end
      end
   endtask

   task automatic resync_byte(input logic [7:0] b, input logic eos);
      char_type     ch;
      len_type      len;
      out_beat_type beat;
      run_q.delete();
      if (eos) begin
         if (have_held) begin
            emit_bytes(held_char, held_len);
         end
         clear_all();
      end else if (build_needed != 0) begin
         if (b >= ASCII_LIMIT && b < CONT_LIMIT) begin
            build_char  = build_char | (char_type'(b) << (8 * build_count[1:0]));
            build_count = build_count + 1'b1;
            if (build_count >= build_needed) begin
               ch  = build_char;
               len = build_needed;
               clear_build();
               pair_char(ch, len);
            end
         end else begin
            clear_build();
            start_char(b);
         end
      end else begin
         start_char(b);
      end
      if (run_q.size() > 0) begin
         beat      = run_q.pop_back();
         beat.last = 1'b1;
         run_q.push_back(beat);
      end
      foreach (run_q[i]) begin
         owed_q.push_back(run_q[i]);
      end
   endtask

   always @(posedge clock) begin
      out_beat_type want;
      if (reset) begin
         clear_all();
         owed_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               $error("unexpected result beat: out_byte %02h last %0d", rsp_out_byte, rsp_last);
               mismatch_count++;
            end else begin
               want = owed_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            resync_byte(req_data_byte, req_end_of_stream);
         end
      end
      bytes_owed <= owed_q.size();
   end

endmodule

>>> dv/utf8_resync_pair_swap_test.sv
// ----------------------------------------------------------------------------
// UTF-8 resync pair swap testbench
// Drives directed and random UTF-8 byte streams with end-of-stream marks
// under varying idle patterns on both channels and reports the verdict of
// the checker.
// ----------------------------------------------------------------------------
module utf8_resync_pair_swap_test;

   localparam int         QUIET_LIMIT = 4000;
   localparam int         HOLD_CYCLES = 60;
   localparam int         PHASE_ITEMS = 64;
   localparam logic [8:0] EOS_BEAT    = 9'h100;

   localparam logic [8:0] DIRECTED [26] = '{
      9'h041, 9'h042,
      9'h000, 9'h043,
      9'h080, 9'h0BF,
      9'h0DF, 9'h0BF, 9'h0E0, 9'h080, 9'h080,
      9'h0F0, 9'h090, 9'h080, 9'h080, 9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h0C3, 9'h05A, EOS_BEAT,
      EOS_BEAT,
      9'h0E5, 9'h080, EOS_BEAT
   };

   logic clock;
   logic reset;
   int   mismatch_count;
   int   bytes_owed;
   int   quiet_cycles;
   int   sent_items;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_ask;
   int   hold_done;
   int   hold_left;

   u8rps_req_if req_bus ();
   u8rps_rsp_if rsp_bus ();

   utf8_resync_pair_swap dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   u8rps_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_data_byte     (req_bus.data_byte),
      .req_end_of_stream (req_bus.end_of_stream),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_out_byte      (rsp_bus.out_byte),
      .rsp_last          (rsp_bus.last),
      .mismatch_count    (mismatch_count),
      .bytes_owed        (bytes_owed)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // A hold-off request forces ready low while hold_left, loaded from HOLD_CYCLES, counts down.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_done     <= 0;
         hold_left     <= 0;
      end else if (hold_ask != hold_done) begin
         rsp_bus.ready <= 1'b0;
         hold_done     <= hold_ask;
         hold_left     <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic eos);
      logic took;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= b;
      req_bus.end_of_stream <= eos;
      took = 1'b0;
      while (!took) begin
         @(negedge clock);
         took = req_bus.ready;
         @(posedge clock);
      end
      sent_items++;
   endtask

   // Sends a lead byte for a character of len bytes followed by conts
   // continuation bytes; fewer than len-1 leaves the character partial.
   task automatic send_char(input int len, input int conts, input bit nul);
      logic [7:0] lead;
      case (len)
         1: begin
            lead = nul ? 8'h00 : 8'($urandom_range(0, 127));
         end
         2: begin
            lead = 8'($urandom_range(8'hC0, 8'hDF));
         end
         3: begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
         end
         default: begin
            lead = 8'($urandom_range(8'hF0, 8'hFF));
         end
      endcase
      send_beat(lead, 1'b0);
      for (int i = 0; i < conts; i++) begin
         send_beat(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
      end
   endtask

   task automatic send_random_chunk();
      int kind;
      int len;
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (kind < 62) begin
         send_char(len, len - 1, $urandom_range(0, 99) < 8);
      end else if (kind < 70) begin
         send_beat(8'($urandom_range(0, 255)), 1'b1);
      end else if (kind < 78) begin
         send_beat(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
      end else if (kind < 90) begin
         len = $urandom_range(2, 4);
         send_char(len, $urandom_range(0, len - 2), 1'b0);
      end else begin
         send_beat(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (bytes_owed != 0);
      @(posedge clock);
   endtask

   initial begin
      int phase_end;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.data_byte     <= 8'h00;
      req_bus.end_of_stream <= 1'b0;
      hold_ask              <= 0;
      recv_idle_pct         <= 83;
      send_idle_pct         = 9;
      sent_items            = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         send_beat(DIRECTED[i][7:0], DIRECTED[i][8]);
      end
      wait_drained();

      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end - PHASE_ITEMS / 2) begin
         send_random_chunk();
      end
      hold_ask      <= hold_ask + 1;
      send_idle_pct = 0;
      repeat (24) send_char(1, 0, 1'b0);
      send_idle_pct = 9;
      while (sent_items < phase_end) begin
         send_random_chunk();
      end
      wait_drained();

      recv_idle_pct <= 9;
      send_idle_pct = 83;
      phase_end     = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
         send_random_chunk();
      end
      wait_drained();

      recv_idle_pct <= 0;
      send_idle_pct = 0;
      phase_end     = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
         send_random_chunk();
      end
      send_beat(8'h00, 1'b1);
      wait_drained();

      repeat (12) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> utf8_resync_pair_swap.f
rtl/core/u8rps_pkg.sv
rtl/core/u8rps_if.sv
rtl/core/utf8_resync_pair_swap.sv
rtl/core/u8rps_checker.sv
dv/u8rps_checker.sv
dv/utf8_resync_pair_swap_test.sv
